>>> hw/rtl/ordered_value_list_top_macros.svh
// ----------------------------------------------------------------------------
// Ordered value list assertion macros
// Concurrent assertion wrappers clocked on clk; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ORDERED_VALUE_LIST_TOP_MACROS_SVH
`define ORDERED_VALUE_LIST_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define OVL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OVL_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OVL_ASSERT(label, prop, msg)
`define OVL_ASSERT_RST(label, prop, msg)
`endif

`endif

>>> hw/rtl/ovl_pkg.sv
// ----------------------------------------------------------------------------
// Ordered value list package
// Command and result beat types, operation and status codes, shared sizes.
// ----------------------------------------------------------------------------
package ovl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int OP_W         = 2;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int POS_W        = 4;
  localparam int CNT_W        = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [CNT_W-1:0]    entry_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

>>> hw/rtl/ovl_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered value list controller
// Two-state sequencer: capture a command, then run its update and result.
// ----------------------------------------------------------------------------
`include "ordered_value_list_top_macros.svh"

module ovl_ctrl
  import ovl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  output ctrl_t ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    ctl.load   = start && (state == S_IDLE);
    ctl.exec   = (state == S_EXEC);
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.exec;
    end
  end

  assign busy = (state == S_EXEC);

  `OVL_ASSERT(a_accept_to_busy, start && !busy |=> busy && !done, "accepted beat did not start")
  `OVL_ASSERT(a_busy_to_done, busy |=> done && !busy, "update did not end with one result beat")
  `OVL_ASSERT_RST(a_reset_idle, rst |=> !busy && !done, "reset did not idle the controller")

endmodule

>>> hw/rtl/ovl_dp.sv
// ----------------------------------------------------------------------------
// Ordered value list datapath
// Row of entry cells with per-cell compare, first-match pick and result beat.
// ----------------------------------------------------------------------------
`include "ordered_value_list_top_macros.svh"

module ovl_dp
  import ovl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  ctrl_t   ctl,
  input  cmd_t    cmd,
  output result_t result
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam logic [CAPACITY-1:0] LSB_ONE = {{(CAPACITY-1){1'b0}}, 1'b1};

  logic [VALUE_W-1:0]  entries [CAPACITY];
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [OP_W-1:0]     op_q;
  logic [VALUE_W-1:0]  value_q;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] first_hit;
  logic [CAPACITY-1:0] below_hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                any_hit;
  logic                full;
  logic                empty;
  logic                do_insert;
  logic                do_delete;
  result_t             result_next;

  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign first_hit = hit_vec & ((~hit_vec) + LSB_ONE);
  assign below_hit = first_hit - LSB_ONE;
  assign any_hit   = |hit_vec;
  assign do_insert = ctl.exec && (op_q == OP_INSERT) && !full;
  assign do_delete = ctl.exec && (op_q == OP_DELETE) && !empty && any_hit;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign valid[g] = (CW'(g) < count);

      always_ff @(posedge clk) begin
        if (ctl.load) begin
          hit_vec[g] <= valid[g] && (entries[g] == cmd.value);
        end
      end

      if (g == 0) begin : g_head
        always_ff @(posedge clk) begin
          if (do_insert) begin
            entries[g] <= value_q;
          end else if (do_delete && !below_hit[g] && (CAPACITY > 1)) begin
            entries[g] <= entries[g+1];
          end
        end
      end else if (g == CAPACITY - 1) begin : g_tail
        always_ff @(posedge clk) begin
          if (do_insert) begin
            entries[g] <= entries[g-1];
          end
        end
      end else begin : g_mid
        always_ff @(posedge clk) begin
          if (do_insert) begin
            entries[g] <= entries[g-1];
          end else if (do_delete && !below_hit[g]) begin
            entries[g] <= entries[g+1];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    count_next  = count;
    result_next = '0;
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          result_next.status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_SEARCH, OP_DELETE: begin
        if (empty) begin
          result_next.status = ST_EMPTY;
        end else if (!any_hit) begin
          result_next.status = ST_NOT_FOUND;
        end else begin
          result_next.position = POS_W'(hit_idx);
          if (op_q == OP_DELETE) begin
            count_next = count - CW'(1);
          end
        end
      end
      default: begin
        result_next.status = ST_OK;
      end
    endcase
    result_next.entry_count = CNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q    <= cmd.operation;
      value_q <= cmd.value;
    end
    if (ctl.exec) begin
      result <= result_next;
    end
  end

  `OVL_ASSERT(a_count_bound, count <= CW'(CAPACITY), "entry count above capacity")
  `OVL_ASSERT(a_search_keeps_count, ctl.exec && op_q == OP_SEARCH |=> $stable(count), "search changed count")
  `OVL_ASSERT(a_full_keeps_count, ctl.exec && op_q == OP_INSERT && full |=> $stable(count), "insert into full list changed count")

endmodule

>>> hw/rtl/ordered_value_list_top.sv
// ----------------------------------------------------------------------------
// Ordered value list
// Bounded head-first list of 32-bit values with insert, search and delete.
// ----------------------------------------------------------------------------
// A command is taken at the clock edge where start is high and busy is low.
// At acceptance of a command every entry cell compares itself with the
// value and the match vector is registered; in the execute state that
// follows, the first match is picked, the cells shift and the result is
// registered. busy is high in the execute state, so no new command is
// taken while one executes. done pulses for one cycle with the result beat and
// the receiver cannot stall it: capture result whenever done is high.
// ----------------------------------------------------------------------------
module ordered_value_list_top
  import ovl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  ctrl_t ctl;

  ovl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  ovl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cmd    (cmd),
    .result (result)
  );

endmodule

>>> tb/sv/ordered_value_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered value list checker
// Watches the command and result channels of the ordered value list. Each
// accepted command beat runs through a local model of the list, and the
// expected result beat is queued. Each result beat is compared field by
// field with the oldest queued expectation. Errors, outstanding beats and
// outcome counts go back to the testbench top.
// ----------------------------------------------------------------------------
module ordered_value_list_checker
  import ovl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    done,
  input  result_t result,
  output int      errors,
  output int      pending,
  output int      full_hits,
  output int      empty_hits,
  output int      miss_hits
);

  logic [VALUE_W-1:0] list_vals [CAPACITY_DEF];
  int                 held;
  result_t            expected_beats [$];
  int                 err_count;
  int                 n_full;
  int                 n_empty;
  int                 n_miss;

  function automatic result_t apply_command(input cmd_t c);
    result_t r;
    int      hit;
    r   = '0;
    hit = -1;
    r.status = ST_OK;
    case (c.operation)
      OP_INSERT: begin
        if (held >= CAPACITY_DEF) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held; i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = c.value;
          held++;
        end
      end
      OP_SEARCH, OP_DELETE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < held; i++) begin
            if (hit < 0 && list_vals[i] == c.value) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.position = POS_W'(hit);
            if (c.operation == OP_DELETE) begin
              for (int i = hit; i + 1 < held; i++) list_vals[i] = list_vals[i+1];
              held--;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_count = CNT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      held = 0;
      expected_beats.delete();
    end else begin
      // retire the result beat before queuing a command taken on the same edge
      if (done) begin
        if (expected_beats.size() == 0) begin
          err_count++;
          $display("%0t: result beat with no command outstanding: status %0d pos %0d count %0d",
                   $time, result.status, result.position, result.entry_count);
        end else begin
          want = expected_beats.pop_front();
          if (result.status !== want.status || result.position !== want.position ||
              result.entry_count !== want.entry_count) begin
            err_count++;
            $display("%0t: mismatch expected status %0d pos %0d count %0d, got status %0d pos %0d count %0d",
                     $time, want.status, want.position, want.entry_count,
                     result.status, result.position, result.entry_count);
          end
          case (want.status)
            ST_FULL:      n_full++;
            ST_EMPTY:     n_empty++;
            ST_NOT_FOUND: n_miss++;
            default: begin
            end
          endcase
        end
      end
      if (start && !busy) expected_beats.push_back(apply_command(cmd));
    end
    pending    <= expected_beats.size();
    errors     <= err_count;
    full_hits  <= n_full;
    empty_hits <= n_empty;
    miss_hits  <= n_miss;
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered value list testbench
// Drives insert, search and delete command beats into the list: a directed
// pass over the empty list, extreme values, duplicates, the tail entry and
// the full list, then random commands in fill and drain phases drawn mostly
// from a small value pool so hits and duplicates are common. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import ovl_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int RANDOM_CMDS = 400;
  localparam int QUIET_TAIL  = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 8;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  int check_errors;
  int beats_pending;
  int full_hits;
  int empty_hits;
  int miss_hits;
  int cycles = 0;
  int op_tally [4];
  bit filling = 1'b0;
  int phase_left = 0;
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ordered_value_list_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  ordered_value_list_checker list_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .errors     (check_errors),
    .pending    (beats_pending),
    .full_hits  (full_hits),
    .empty_hits (empty_hits),
    .miss_hits  (miss_hits)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // hold start until the beat is taken; leave it high for a back-to-back beat
  task automatic issue(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v);
    cmd_t c;
    c.operation = op;
    c.value     = v;
    start <= 1'b1;
    cmd   <= c;
    op_tally[op]++;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 65) return value_pool[$urandom_range(POOL_SIZE-1)];
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input bit fill);
    int r;
    r = $urandom_range(99);
    if (r < 4) return OP_RESERVED;
    if (fill) begin
      if (r < 64) return OP_INSERT;
      if (r < 80) return OP_SEARCH;
      return OP_DELETE;
    end
    if (r < 25) return OP_INSERT;
    if (r < 50) return OP_SEARCH;
    return OP_DELETE;
  endfunction

  initial begin
    int sent;
    logic [OP_W-1:0] op;
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list
    issue(OP_SEARCH, 32'h0000_0000);
    issue(OP_DELETE, 32'hFFFF_FFFF);
    issue(OP_RESERVED, 32'h1234_5678);
    // extremes and a duplicate
    issue(OP_INSERT, 32'h8000_0000);
    issue(OP_INSERT, 32'h7FFF_FFFF);
    issue(OP_INSERT, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'h0000_0000);
    issue(OP_INSERT, 32'h7FFF_FFFF);
    issue(OP_SEARCH, 32'h8000_0000);
    issue(OP_DELETE, 32'h7FFF_FFFF);
    issue(OP_SEARCH, 32'h7FFF_FFFF);
    issue(OP_SEARCH, 32'h0001_2345);
    issue(OP_DELETE, 32'hFFFF_FFFE);
    issue(OP_RESERVED, 32'h8000_0000);
    // fill, overflow, then the tail entry
    for (int i = 0; i < 12; i++) issue(OP_INSERT, $urandom);
    issue(OP_INSERT, 32'h5555_AAAA);
    issue(OP_SEARCH, 32'h8000_0000);
    issue(OP_DELETE, 32'h8000_0000);

    sent = 0;
    while (sent < RANDOM_CMDS) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      if (sent < RANDOM_CMDS - QUIET_TAIL && $urandom_range(3) == 0)
        pause($urandom_range(1, 8));
      op = pick_op(filling);
      issue(op, pick_value());
      if (op != OP_RESERVED) sent++;
    end
    start <= 1'b0;

    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Covered %0d commands: %0d insert, %0d search, %0d delete, %0d reserved code",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[OP_INSERT], op_tally[OP_SEARCH], op_tally[OP_DELETE],
             op_tally[OP_RESERVED]);
    $display("Outcomes seen: %0d list full, %0d list empty, %0d not found, %0d failures",
             full_hits, empty_hits, miss_hits, check_errors);
    if (check_errors == 0 && beats_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
